/* rtl/sidasc_pkg.sv */
package sidasc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Decimal digits needed for a magnitude of 2^(width-1):
  // floor((width-1) * log10(2)) + 1, with log10(2) ~ 1233/4096.
  function automatic int unsigned num_digits(int unsigned width);
    return ((width - 1) * 1233) / 4096 + 1;
  endfunction

endpackage

/* rtl/sidasc_dabble.sv */
module sidasc_dabble #(
  parameter int unsigned VALUE_WIDTH = sidasc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   idle_o,
  output logic                   done_o,
  input  logic                   take_i,
  output logic                   negative_o,
  output logic [4*sidasc_pkg::num_digits(VALUE_WIDTH)-1:0] bcd_o
);
  import sidasc_pkg::*;

  localparam int unsigned NDIG  = num_digits(VALUE_WIDTH);
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DONE  = 3'b100
  } dab_state_e;

  dab_state_e             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d, bcd_adj;
  logic                   neg_q, neg_d;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int i = 0; i < int'(NDIG); i++) begin
      dig = bcd_q[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[VALUE_WIDTH-1];
          mag_d   = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;
          bcd_d   = '0;
          cnt_d   = CNT_W'(VALUE_WIDTH);
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bcd_d = {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign idle_o     = (state_q == ST_IDLE);
  assign done_o     = (state_q == ST_DONE);
  assign negative_o = neg_q;
  assign bcd_o      = bcd_q;

endmodule

/* rtl/sidasc_emit.sv */
module sidasc_emit #(
  parameter int unsigned VALUE_WIDTH = sidasc_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       negative_i,
  input  logic [4*sidasc_pkg::num_digits(VALUE_WIDTH)-1:0] bcd_i,
  output logic       idle_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);
  import sidasc_pkg::*;

  localparam int unsigned NDIG  = num_digits(VALUE_WIDTH);
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(NDIG + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SIGN  = 4'b0010,
    ST_SKIP  = 4'b0100,
    ST_DIGIT = 4'b1000
  } emit_state_e;

  emit_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic             vld_q, vld_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic [3:0]       top_dig;
  logic             out_free;

  assign top_dig  = bcd_q[BCD_W-1 -: 4];
  assign out_free = !vld_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bcd_d   = bcd_q;
    data_d  = data_q;
    last_d  = last_q;
    vld_d   = vld_q && !m_axis_tready_i;
    case (state_q)
      ST_IDLE: begin
        if (load_i) begin
          bcd_d   = bcd_i;
          cnt_d   = CNT_W'(NDIG);
          state_d = negative_i ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          vld_d   = 1'b1;
          data_d  = ASCII_MINUS;
          last_d  = 1'b0;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_dig == 4'd0 && cnt_q != CNT_W'(1)) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          vld_d  = 1'b1;
          data_d = ASCII_ZERO | {4'd0, top_dig};
          last_d = (cnt_q == CNT_W'(1));
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          cnt_d  = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    data_q <= data_d;
    last_q <= last_d;
  end

  assign idle_o          = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Timing: an input transfer loads the converter, which shifts the magnitude bit-serially
//   through the shift-and-add-3 steps and then hands the digits to the emitter; the emitter
//   sends a leading minus sign, skips leading zeros and then sends the digits. A new input is
//   accepted only once the converter has handed its digits over; emission of the text overlaps
//   the next conversion, and a handoff waits while the emitter still holds the previous text.
// Reset: rst_ni (asynchronous, active low) idles both units and drops any pending text.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = sidasc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream, one signed integer per transfer.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,  // [VALUE_WIDTH-1:0] value
  // Output stream, one ASCII character per transfer.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [7:0]                          m_axis_tdata_o,  // [7:0] text_byte
  output logic                                m_axis_tlast_o   // last_byte
);
  import sidasc_pkg::*;

  localparam int unsigned NDIG  = num_digits(VALUE_WIDTH);
  localparam int unsigned BCD_W = 4 * NDIG;

  logic             s_xfer;
  logic             conv_idle;
  logic             conv_done;
  logic             conv_neg;
  logic [BCD_W-1:0] conv_bcd;
  logic             emit_idle;
  logic             handoff;

  // Accept a new value whenever the converter is free; the emitter may
  // still be sending the previous number's text.
  assign s_axis_tready_o = conv_idle;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  // Hand the finished digits over as soon as the emitter has loaded its last digit.
  assign handoff = conv_done && emit_idle;

  // Magnitude formed on load, then shifted in one bit per cycle into the BCD digits.
  sidasc_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dabble (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (s_xfer),
    .value_i    (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .idle_o     (conv_idle),
    .done_o     (conv_done),
    .take_i     (handoff),
    .negative_o (conv_neg),
    .bcd_o      (conv_bcd)
  );

  // Sign, leading-zero skip, then one digit per output transfer, MSD first.
  sidasc_emit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (handoff),
    .negative_i      (conv_neg),
    .bcd_i           (conv_bcd),
    .idle_o          (emit_idle),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Converter goes busy right after taking a value.
  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("converter still ready after an input transfer");

  // A handoff releases the converter in the next cycle.
  a_handoff_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    handoff |=> !conv_done)
    else $error("converter still holds digits after handoff");

  // Only a minus sign or a decimal digit leaves the block.
  a_char_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o == ASCII_MINUS) ||
                        (m_axis_tdata_o >= ASCII_ZERO && m_axis_tdata_o <= 8'd57))
    else $error("character out of range");

  // The sign never ends a number.
  a_sign_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o != ASCII_MINUS))
    else $error("minus sign marked as last character");

endmodule
